// ===== sv/ple_pkg.sv =====
// shared types and constants of the positional list engine
package ple_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned POS_W = 7;
  localparam int unsigned ST_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_PRIOR  = 3'd4,
    OP_NEXT   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NOPRIOR  = 3'd4,
    ST_NONEXT   = 3'd5
  } status_e;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic locate;
  } cell_ctl_t;

endpackage

// ===== sv/ple_if.sv =====
// request and response channel interfaces of the positional list engine
interface ple_req_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  import ple_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       opcode;
  logic [POS_W-1:0]      position;
  logic [DATA_WIDTH-1:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface ple_rsp_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  import ple_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ST_W-1:0]       status;
  logic [DATA_WIDTH-1:0] data;
  logic [POS_W-1:0]      found_position;
  logic [POS_W-1:0]      length;
  logic                  is_empty;

  modport source (output valid, output status, output data, output found_position,
                  output length, output is_empty, input ready);
  modport sink   (input valid, input status, input data, input found_position,
                  input length, input is_empty, output ready);
endinterface

// ===== sv/ple_cell.sv =====
// one list cell: holds an element, shifts with its neighbors, forwards the search result
module ple_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned LEN_W      = 7,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  ple_pkg::cell_ctl_t    ctl_i,
  input  logic [IDX_W-1:0]      target_i,
  input  logic [LEN_W-1:0]      len_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] lo_data_i,
  input  logic [DATA_WIDTH-1:0] hi_data_i,
  input  logic                  hi_found_i,
  input  logic [LEN_W-1:0]      hi_pos_i,
  input  logic [DATA_WIDTH-1:0] hi_rdata_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  found_o,
  output logic [LEN_W-1:0]      pos_o,
  output logic [DATA_WIDTH-1:0] rdata_o
);
  import ple_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);
  localparam logic [LEN_W-1:0] MyLen = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] MyPos = LEN_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  found_q;
  logic [LEN_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  hit;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_up) begin
      if (MyIdx > target_i) begin
        data_d = lo_data_i;
      end else if (MyIdx == target_i) begin
        data_d = value_i;
      end
    end else if (ctl_i.shift_down) begin
      if (MyIdx >= target_i) begin
        data_d = hi_data_i;
      end
    end
  end

  assign hit = ctl_i.locate ? ((data_q == value_i) && (MyLen < len_i)) : (MyIdx == target_i);

  // lower cells win, so the first hit reaches cell zero
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (hit) begin
      found_q <= 1'b1;
      pos_q   <= MyPos;
      rdata_q <= data_q;
    end else begin
      found_q <= hi_found_i;
      pos_q   <= hi_pos_i;
      rdata_q <= hi_rdata_i;
    end
  end

  assign data_o  = data_q;
  assign found_o = found_q;
  assign pos_o   = pos_q;
  assign rdata_o = rdata_q;

endmodule

// ===== sv/positional_list_engine.sv =====
// top level of the positional list engine: control, length and the cell chain
//
//   channel | dir | modport | item
//   req_i   | in  | sink    | opcode, position, value
//   rsp_o   | out | source  | status, data, found_position, length, is_empty
//
// insert, delete, clear and errors go from accept through S_EXEC and S_DONE to result valid
// read, prior, next and locate also pass through S_SWEEP before S_DONE: the search result
// moves one cell a cycle down the chain to cell zero
// one item at a time; the next item is taken while a result waits in rsp_o
// reset empties the list; element contents are kept and never cleared
module positional_list_engine #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ple_req_if.sink         req_i,
  ple_rsp_if.source       rsp_o
);
  import ple_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
  localparam logic [LEN_W-1:0] CapLen  = LEN_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LastCnt = IDX_W'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;
  logic                  swept_q, swept_d;
  logic [ST_W-1:0]       res_st_q, res_st_d;
  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic                  out_valid_q;
  logic [ST_W-1:0]       out_st_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic [POS_W-1:0]      out_fpos_q;
  logic [POS_W-1:0]      out_len_q;
  logic                  out_empty_q;
  logic                  out_load;

  logic                  accept;
  logic [CMP_W-1:0]      p, l, tgt_full;
  logic                  pos_ok;
  logic [IDX_W-1:0]      target;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
  logic                  red_found  [CAPACITY+1];
  logic [LEN_W-1:0]      red_pos    [CAPACITY+1];
  logic [DATA_WIDTH-1:0] red_rdata  [CAPACITY+1];

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign p      = CMP_W'(pos_q);
  assign l      = CMP_W'(len_q);
  assign pos_ok = (p >= CMP_W'(1)) && (p <= l);

  always_comb begin
    case (op_q)
      OP_PRIOR: tgt_full = p - CMP_W'(2);
      OP_NEXT:  tgt_full = p;
      default:  tgt_full = p - CMP_W'(1);
    endcase
  end
  assign target = tgt_full[IDX_W-1:0];

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    swept_d  = swept_q;
    res_st_d = res_st_q;
    ctl      = '0;
    ctl.locate = (op_q == OP_LOCATE);
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_st_d = ST_OK;
        swept_d  = 1'b0;
        cnt_d    = '0;
        state_d  = S_DONE;
        case (op_q)
          OP_READ: begin
            if (!pos_ok) begin
              res_st_d = ST_BADPOS;
            end else begin
              swept_d = 1'b1;
              state_d = S_SWEEP;
            end
          end
          OP_LOCATE: begin
            swept_d = 1'b1;
            state_d = S_SWEEP;
          end
          OP_INSERT: begin
            if (len_q == CapLen) begin
              res_st_d = ST_FULL;
            end else if ((p < CMP_W'(1)) || (p > l + CMP_W'(1))) begin
              res_st_d = ST_BADPOS;
            end else begin
              ctl.shift_up = 1'b1;
              len_d = len_q + LEN_W'(1);
            end
          end
          OP_DELETE: begin
            if (!pos_ok) begin
              res_st_d = ST_BADPOS;
            end else begin
              ctl.shift_down = 1'b1;
              len_d = len_q - LEN_W'(1);
            end
          end
          OP_PRIOR: begin
            if (!pos_ok) begin
              res_st_d = ST_BADPOS;
            end else if (p == CMP_W'(1)) begin
              res_st_d = ST_NOPRIOR;
            end else begin
              swept_d = 1'b1;
              state_d = S_SWEEP;
            end
          end
          OP_NEXT: begin
            if (!pos_ok) begin
              res_st_d = ST_BADPOS;
            end else if (p == l) begin
              res_st_d = ST_NONEXT;
            end else begin
              swept_d = 1'b1;
              state_d = S_SWEEP;
            end
          end
          OP_CLEAR: begin
            len_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == LastCnt) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      swept_q     <= 1'b0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      swept_q  <= swept_d;
      res_st_q <= res_st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.opcode;
      pos_q <= req_i.position;
      val_q <= req_i.value;
    end
    if (out_load) begin
      out_len_q   <= POS_W'(len_q);
      out_empty_q <= (len_q == '0);
      out_st_q    <= res_st_q;
      out_data_q  <= '0;
      out_fpos_q  <= '0;
      if (swept_q) begin
        if (op_q == OP_LOCATE) begin
          out_st_q   <= red_found[0] ? ST_OK : ST_NOTFOUND;
          out_fpos_q <= red_found[0] ? POS_W'(red_pos[0]) : '0;
        end else begin
          out_st_q   <= ST_OK;
          out_data_q <= red_rdata[0];
        end
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_st_q;
  assign rsp_o.data           = out_data_q;
  assign rsp_o.found_position = out_fpos_q;
  assign rsp_o.length         = out_len_q;
  assign rsp_o.is_empty       = out_empty_q;

  // cell chain
  assign red_found[CAPACITY] = 1'b0;
  assign red_pos[CAPACITY]   = '0;
  assign red_rdata[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lo_data, hi_data;

    if (i == 0) begin : g_lo_edge
      assign lo_data = '0;
    end else begin : g_lo
      assign lo_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi_edge
      assign hi_data = '0;
    end else begin : g_hi
      assign hi_data = cell_data[i+1];
    end

    ple_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .LEN_W      (LEN_W),
      .IDX        (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .target_i   (target),
      .len_i      (len_q),
      .value_i    (val_q),
      .lo_data_i  (lo_data),
      .hi_data_i  (hi_data),
      .hi_found_i (red_found[i+1]),
      .hi_pos_i   (red_pos[i+1]),
      .hi_rdata_i (red_rdata[i+1]),
      .data_o     (cell_data[i]),
      .found_o    (red_found[i]),
      .pos_o      (red_pos[i]),
      .rdata_o    (red_rdata[i])
    );
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= CapLen)
    else $error("list length above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> state_q == S_EXEC)
    else $error("accepted item not executed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q != S_EXEC) |=> $stable(len_q))
    else $error("length changed outside execution");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_SWEEP) |=> (state_q == S_SWEEP || state_q == S_DONE))
    else $error("search left early");

endmodule
